@@ rtl/cbt_pkg.sv @@
// Shared types, constants and lerp arithmetic for the cubic Bezier tessellator.
package cbt_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int STEP_BITS   = 6;
	localparam int CNT_BITS    = $clog2(T_FRAC_BITS + 1);
	localparam int NUM_AXES    = 2;

	localparam logic [STEP_BITS-1:0] STEPS_RESET = STEP_BITS'(63);
	localparam logic                 REG_STEPS   = 1'b0;

	typedef logic signed [COORD_BITS-1:0]           coord_t;
	typedef logic signed [COORD_BITS:0]             diff_t;
	typedef logic        [T_FRAC_BITS:0]            tval_t;
	typedef logic signed [T_FRAC_BITS+1:0]          tsgn_t;
	typedef logic signed [COORD_BITS+T_FRAC_BITS+2:0] prod_t;
	typedef logic        [STEP_BITS-1:0]            steps_t;
	typedef logic        [CNT_BITS-1:0]             cnt_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RUN
	} seq_state_t;

	// First half of a lerp: (b - a) * t at full width.
	function automatic prod_t lerp_mul(input coord_t a, input coord_t b, input tval_t t);
		diff_t d;
		tsgn_t ts;
		d  = diff_t'(b) - diff_t'(a);
		ts = signed'({1'b0, t});
		return prod_t'(d) * prod_t'(ts);
	endfunction

	// Second half: a + floor(product / 2^T_FRAC_BITS). The result lies between
	// the two operands, so the low coordinate bits are exact.
	function automatic coord_t lerp_add(input coord_t a, input prod_t p);
		prod_t sh;
		sh = p >>> T_FRAC_BITS;
		return coord_t'(a + sh[COORD_BITS-1:0]);
	endfunction

endpackage

@@ rtl/cubic_bezier_tessellator.sv @@
// Top level of the cubic Bezier tessellator: segment sequencer and lerp pipeline.
//
// The block takes one cubic Bezier segment per beat on the seg channel
// (start, two control points, end, all signed Q8.8, and a final_segment flag)
// and returns a run of curve points on the pt channel, one point per beat.
// For steps_per_segment = s it emits the points at t = j/s for j = 0 .. s-1,
// and for a final segment also the point at t = 1; last_point marks the last
// point of each segment. A value of zero in the register is taken as one.
// The register sits at byte address 0 of the APB port and should only be
// written while the block is idle.
// On acceptance the sequencer first works out 2^16 / s with a bit-serial
// divider, then issues one point per cycle while the receiver does not stall
// into a six-stage pipeline: three levels of de Casteljau interpolation,
// each a multiply stage followed by an add stage. A new segment is taken
// once every point of the previous one has been issued, even while its
// last points are still in the pipeline.
// While a point waits with pt_ready low the whole pipeline holds and the
// sequencer pauses issuing; nothing is lost or repeated. Reset (arst_n low)
// empties the pipeline, returns the sequencer to idle and sets the register to 63.
module cubic_bezier_tessellator (
	input  logic            clk,
	input  logic            arst_n,
	// Segment channel
	input  logic            seg_valid,
	output logic            seg_ready,
	input  cbt_pkg::coord_t start_x,
	input  cbt_pkg::coord_t start_y,
	input  cbt_pkg::coord_t ctrl1_x,
	input  cbt_pkg::coord_t ctrl1_y,
	input  cbt_pkg::coord_t ctrl2_x,
	input  cbt_pkg::coord_t ctrl2_y,
	input  cbt_pkg::coord_t end_x,
	input  cbt_pkg::coord_t end_y,
	input  logic            final_segment,
	// Point channel
	output logic            pt_valid,
	input  logic            pt_ready,
	output cbt_pkg::coord_t point_x,
	output cbt_pkg::coord_t point_y,
	output logic            last_point,
	// Configuration port
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import cbt_pkg::*;

	// Configuration register.
	steps_t steps_cfg_q;
	logic   cfg_wr;

	// Sequencer state.
	seq_state_t state_q, state_nxt;
	coord_t     hold_q [NUM_AXES][4];
	steps_t     steps_q;
	steps_t     last_idx_q;
	steps_t     j_q;
	steps_t     rem_q;
	steps_t     acc_q;
	tval_t      q_q;
	tval_t      t_q;
	cnt_t       div_cnt_q;
	logic       accept;
	logic       issue;
	logic       en;

	// Divider and step accumulator arithmetic.
	logic [STEP_BITS:0] div_shift;
	logic               div_fit;
	logic [STEP_BITS:0] acc_sum;
	logic               acc_wrap;
	steps_t             steps_eff;

	// Pipeline stages.
	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic   last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	tval_t  t_s1, t_s2, t_s3, t_s4;
	prod_t  prod_s1 [NUM_AXES][3];
	coord_t base_s1 [NUM_AXES][3];
	coord_t l1_s2   [NUM_AXES][3];
	prod_t  prod_s3 [NUM_AXES][2];
	coord_t base_s3 [NUM_AXES][2];
	coord_t l2_s4   [NUM_AXES][2];
	prod_t  prod_s5 [NUM_AXES];
	coord_t base_s5 [NUM_AXES];
	coord_t pt_s6   [NUM_AXES];

	prod_t  prod1_c [NUM_AXES][3];
	coord_t l1_c    [NUM_AXES][3];
	prod_t  prod3_c [NUM_AXES][2];
	coord_t l2_c    [NUM_AXES][2];
	prod_t  prod5_c [NUM_AXES];
	coord_t pt_c    [NUM_AXES];

	// ------------------------------------------------------------------
	// Configuration port. Only bit 2 of the address selects a register.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEPS);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_STEPS) begin
			prdata = 32'(steps_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_cfg_q <= STEPS_RESET;
		end else if (cfg_wr) begin
			steps_cfg_q <= pwdata[STEP_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	assign en        = !v_s6 || pt_ready;
	assign steps_eff = (steps_cfg_q == '0) ? STEP_BITS'(1) : steps_cfg_q;

	// The dividend is 2^T_FRAC_BITS, so only its first bit is a one.
	assign div_shift = {rem_q, (div_cnt_q == cnt_t'(T_FRAC_BITS))};
	assign div_fit   = div_shift >= {1'b0, steps_q};

	// Running remainder of j * 2^F / s; it stays below s, so one compare
	// and subtract keeps it in range.
	assign acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
	assign acc_wrap = acc_sum >= {1'b0, steps_q};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (seg_valid) begin
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (div_cnt_q == '0) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (en && (j_q == last_idx_q)) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		seg_ready = 1'b0;
		issue     = 1'b0;
		case (state_q)
			S_IDLE:  seg_ready = 1'b1;
			S_DIV:   seg_ready = 1'b0;
			S_RUN:   issue     = en;
			default: seg_ready = 1'b0;
		endcase
	end

	assign accept = seg_valid && seg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q[0][0] <= start_x;
			hold_q[1][0] <= start_y;
			hold_q[0][1] <= ctrl1_x;
			hold_q[1][1] <= ctrl1_y;
			hold_q[0][2] <= ctrl2_x;
			hold_q[1][2] <= ctrl2_y;
			hold_q[0][3] <= end_x;
			hold_q[1][3] <= end_y;
			steps_q      <= steps_eff;
			last_idx_q   <= steps_eff - STEP_BITS'(1) + STEP_BITS'(final_segment);
			rem_q        <= '0;
			q_q          <= '0;
			div_cnt_q    <= cnt_t'(T_FRAC_BITS);
		end
		if (state_q == S_DIV) begin
			rem_q     <= div_fit ? steps_t'(div_shift - {1'b0, steps_q})
			                     : div_shift[STEP_BITS-1:0];
			q_q       <= {q_q[T_FRAC_BITS-1:0], div_fit};
			div_cnt_q <= div_cnt_q - cnt_t'(1);
			j_q       <= '0;
			t_q       <= '0;
			acc_q     <= '0;
		end
		if (issue) begin
			j_q   <= j_q + STEP_BITS'(1);
			t_q   <= t_q + q_q + tval_t'(acc_wrap);
			acc_q <= acc_wrap ? steps_t'(acc_sum - {1'b0, steps_q})
			                  : acc_sum[STEP_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Interpolation pipeline: multiply and add stage for each level.
	// ------------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			for (int i = 0; i < 3; i++) begin
				prod1_c[k][i] = lerp_mul(hold_q[k][i], hold_q[k][i+1], t_q);
				l1_c[k][i]    = lerp_add(base_s1[k][i], prod_s1[k][i]);
			end
			for (int i = 0; i < 2; i++) begin
				prod3_c[k][i] = lerp_mul(l1_s2[k][i], l1_s2[k][i+1], t_s2);
				l2_c[k][i]    = lerp_add(base_s3[k][i], prod_s3[k][i]);
			end
			prod5_c[k] = lerp_mul(l2_s4[k][0], l2_s4[k][1], t_s4);
			pt_c[k]    = lerp_add(base_s5[k], prod_s5[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_q;
			last_s1 <= (j_q == last_idx_q);
			prod_s1 <= prod1_c;
			for (int k = 0; k < NUM_AXES; k++) begin
				for (int i = 0; i < 3; i++) begin
					base_s1[k][i] <= hold_q[k][i];
				end
			end

			t_s2    <= t_s1;
			last_s2 <= last_s1;
			l1_s2   <= l1_c;

			t_s3    <= t_s2;
			last_s3 <= last_s2;
			prod_s3 <= prod3_c;
			for (int k = 0; k < NUM_AXES; k++) begin
				for (int i = 0; i < 2; i++) begin
					base_s3[k][i] <= l1_s2[k][i];
				end
			end

			t_s4    <= t_s3;
			last_s4 <= last_s3;
			l2_s4   <= l2_c;

			last_s5 <= last_s4;
			prod_s5 <= prod5_c;
			for (int k = 0; k < NUM_AXES; k++) begin
				base_s5[k] <= l2_s4[k][0];
			end

			last_s6 <= last_s5;
			pt_s6   <= pt_c;
		end
	end

	assign pt_valid   = v_s6;
	assign point_x    = pt_s6[0];
	assign point_y    = pt_s6[1];
	assign last_point = last_s6;

`ifndef NO_ASSERTIONS
	// The step counter never runs past the last point of the segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (j_q <= last_idx_q))
		else $error("step counter beyond last point");

	// The running remainder stays below the step count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (acc_q < steps_q))
		else $error("step remainder out of range");

	// When the divider hands over, quotient and remainder rebuild 2^F.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && $past(state_q) == S_DIV) |->
		((32'(q_q) * 32'(steps_q) + 32'(rem_q)) == (32'(1) << T_FRAC_BITS)))
		else $error("divider result inconsistent");

	// The extra point of a final segment lands exactly on t = 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && j_q == steps_q) |->
		(t_q == (tval_t'(1) << T_FRAC_BITS)))
		else $error("end point parameter not one");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the cubic Bezier tessellator top level.
`timescale 1ns / 1ps

module tb;

	import cbt_pkg::*;

	// Byte address of the step-count register on the configuration port.
	localparam logic [2:0] STEPS_ADDR = 3'(4 * REG_STEPS);
	// Longest stretch without any beat on either channel before the run is abandoned.
	// The worst honest case is the receiver's long hold-off plus a full pipeline
	// drain, or a long sender gap behind a slow segment, both well below this.
	localparam int QUIET_LIMIT = 3000;
	// Cycles the receiver refuses points for, once, to back the block up.
	localparam int LONG_HOLD = 400;

	// One segment beat, field for field as it appears on the seg channel.
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t ctrl2_x;
		coord_t ctrl2_y;
		coord_t end_x;
		coord_t end_y;
		logic   final_seg;
	} segment_t;

	// One point beat as expected on the pt channel.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} curve_point_t;

	// How keen the receiver is to take points during one stretch.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY
	} rx_pace_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        seg_valid = 1'b0;
	logic        seg_ready;
	segment_t    seg_bus   = '0;
	logic        pt_valid;
	logic        pt_ready  = 1'b0;
	coord_t      point_x;
	coord_t      point_y;
	logic        last_point;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	// Segments waiting to be offered, and the points they are known to produce.
	segment_t     seg_backlog[$];
	curve_point_t expected_points[$];

	// The testbench's own copy of the step-count register.
	steps_t      steps_cfg = STEPS_RESET;

	int unsigned segs_queued   = 0;
	int unsigned segs_accepted = 0;
	int unsigned points_seen   = 0;
	int unsigned error_count   = 0;
	bit          seg_taken     = 1'b0;

	always #5 clk = ~clk;

	cubic_bezier_tessellator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.seg_valid     (seg_valid),
		.seg_ready     (seg_ready),
		.start_x       (seg_bus.start_x),
		.start_y       (seg_bus.start_y),
		.ctrl1_x       (seg_bus.ctrl1_x),
		.ctrl1_y       (seg_bus.ctrl1_y),
		.ctrl2_x       (seg_bus.ctrl2_x),
		.ctrl2_y       (seg_bus.ctrl2_y),
		.end_x         (seg_bus.end_x),
		.end_y         (seg_bus.end_y),
		.final_segment (seg_bus.final_seg),
		.pt_valid      (pt_valid),
		.pt_ready      (pt_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.last_point    (last_point),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Linear interpolation with t in unsigned Q1.16. The product is kept at
	// 64 bits and the arithmetic shift gives floor division, so negative
	// differences round towards minus infinity just as the hardware should.
	function automatic coord_t lerp_q16(coord_t a, coord_t b, longint t);
		longint prod;
		prod = (longint'(b) - longint'(a)) * t;
		return coord_t'(longint'(a) + (prod >>> T_FRAC_BITS));
	endfunction

	// Three levels of de Casteljau on one axis.
	function automatic coord_t casteljau(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
			longint t);
		coord_t a, b, c, d, e;
		a = lerp_q16(p0, p1, t);
		b = lerp_q16(p1, p2, t);
		c = lerp_q16(p2, p3, t);
		d = lerp_q16(a, b, t);
		e = lerp_q16(b, c, t);
		return lerp_q16(d, e, t);
	endfunction

	// Works out every point that one accepted segment must produce and queues
	// them in order. A register value of zero behaves as a single step, and a
	// final segment gains one extra point at t = 1 exactly.
	function automatic void predict_points(segment_t s);
		int unsigned  n_steps;
		int unsigned  total;
		int unsigned  j;
		longint       t;
		curve_point_t p;
		n_steps = (steps_cfg == 0) ? 1 : int'(steps_cfg);
		total   = n_steps + (s.final_seg ? 1 : 0);
		for (j = 0; j < total; j++) begin
			if (j >= n_steps) begin
				t = longint'(1) << T_FRAC_BITS;
			end else begin
				t = (longint'(j) << T_FRAC_BITS) / n_steps;
			end
			p.x    = casteljau(s.start_x, s.ctrl1_x, s.ctrl2_x, s.end_x, t);
			p.y    = casteljau(s.start_y, s.ctrl1_y, s.ctrl2_y, s.end_y, t);
			p.last = (j + 1 == total);
			expected_points = {expected_points, p};
		end
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		$display("%0t ns: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sampled at the rising edge, before the block's own updates
	// land, so every value seen here is the one present at the edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		curve_point_t want;
		if (arst_n) begin
			seg_taken <= seg_valid && seg_ready;
			// A segment beat: its expected points are known from this moment.
			if (seg_valid && seg_ready) begin
				predict_points(seg_bus);
				segs_accepted++;
			end
			// A point beat: compare with the oldest point still owed.
			if (pt_valid && pt_ready) begin
				points_seen++;
				if (expected_points.size() == 0) begin
					flag_error($sformatf("point with nothing expected: x %0d y %0d last %0b",
						point_x, point_y, last_point));
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) begin
						flag_error($sformatf("point_x expected %0d, got %0d",
							want.x, point_x));
					end
					if (point_y !== want.y) begin
						flag_error($sformatf("point_y expected %0d, got %0d",
							want.y, point_y));
					end
					if (last_point !== want.last) begin
						flag_error($sformatf("last_point expected %0b, got %0b",
							want.last, last_point));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Segment driver: works in bursts, with gaps between them that range from
	// none at all to longer than a whole segment, so the gaps land on every
	// phase of the block's work (divider, issue, pipeline drain).
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n && (!seg_valid || seg_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				seg_valid <= 1'b0;
			end else if (seg_backlog.size() != 0) begin
				seg_bus   <= seg_backlog.pop_front();
				seg_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 10);
					case ($urandom_range(0, 2))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 8);
						default: gap_left = $urandom_range(10, 120);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				seg_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Point receiver: stretches of free flow, light stalling and heavy
	// stalling follow each other at random. Once, after a few hundred points,
	// it refuses everything for a long while so that the pipeline fills and
	// the block has to hold off the segment beats the driver keeps offering.
	// ------------------------------------------------------------------
	rx_pace_t    rx_pace      = RX_FREE;
	int unsigned rx_pace_left = 0;
	int unsigned rx_hold_left = 0;
	bit          long_hold_done = 1'b0;

	always @(negedge clk) begin
		logic take;
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			take = 1'b0;
		end else if (!long_hold_done && points_seen >= 300) begin
			long_hold_done = 1'b1;
			rx_hold_left   = LONG_HOLD - 1;
			take           = 1'b0;
		end else begin
			if (rx_pace_left == 0) begin
				rx_pace      = rx_pace_t'($urandom_range(0, 2));
				rx_pace_left = $urandom_range(20, 200);
			end
			rx_pace_left--;
			case (rx_pace)
				RX_FREE:  take = 1'b1;
				RX_LIGHT: take = ($urandom_range(0, 3) != 0);
				default:  take = ($urandom_range(0, 2) == 0);
			endcase
		end
		pt_ready <= take;
	end

	// ------------------------------------------------------------------
	// Watchdog: counts cycles in which no beat moves on either channel.
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((seg_valid && seg_ready) || (pt_valid && pt_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t ns: no beat for %0d cycles, %0d points still owed",
					$time, QUIET_LIMIT, expected_points.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic void add_segment(coord_t sx, coord_t sy, coord_t c1x, coord_t c1y,
			coord_t c2x, coord_t c2y, coord_t ex, coord_t ey, logic fin);
		segment_t s;
		s.start_x   = sx;
		s.start_y   = sy;
		s.ctrl1_x   = c1x;
		s.ctrl1_y   = c1y;
		s.ctrl2_x   = c2x;
		s.ctrl2_y   = c2y;
		s.end_x     = ex;
		s.end_y     = ey;
		s.final_seg = fin;
		seg_backlog = {seg_backlog, s};
		segs_queued++;
	endfunction

	// Coordinates lean towards the extremes and small values, where rounding
	// and the width of the differences are most likely to go wrong.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'($urandom_range(0, 16)) - coord_t'(8);
			3: return coord_t'($urandom_range(0, 2048)) - coord_t'(1024);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Queues n segments, mostly as connected paths: each segment starts where
	// the previous one ended and only the path's last segment is final. About
	// one pick in six adds a stray segment with random content and a random flag.
	function automatic void queue_paths(int unsigned n);
		int unsigned left;
		int unsigned path_len;
		int unsigned k;
		coord_t      px, py, qx, qy;
		left = n;
		while (left != 0) begin
			if ($urandom_range(0, 5) == 0) begin
				add_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					1'($urandom_range(0, 1)));
				left--;
			end else begin
				path_len = $urandom_range(1, 4);
				if (path_len > left) begin
					path_len = left;
				end
				px = pick_coord();
				py = pick_coord();
				for (k = 0; k < path_len; k++) begin
					qx = pick_coord();
					qy = pick_coord();
					add_segment(px, py, pick_coord(), pick_coord(), pick_coord(),
						pick_coord(), qx, qy, k + 1 == path_len);
					px = qx;
					py = qy;
				end
				left -= path_len;
			end
		end
	endfunction

	// Returns at a falling edge once every queued segment has been taken and
	// every point it owes has arrived. Each segment always owes at least one
	// point, so the block is idle by then.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (!(segs_accepted == segs_queued && expected_points.size() == 0));
	endtask

	// Writes the step-count register, then reads it back. Only the low six
	// bits of the write data are kept by the register.
	task automatic set_steps(logic [31:0] word);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= STEPS_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		steps_cfg = word[STEP_BITS-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (prdata !== 32'(steps_cfg)) begin
			flag_error($sformatf("step register read expected %0d, got %0d",
				steps_cfg, prdata));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		// Reset once, released away from the edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed segments at the reset setting of 63 steps. Equal control
		// points, the full range in both directions, swings from one extreme
		// to the other, small values either side of zero where floor rounding
		// shows, and alternating bit patterns.
		add_segment('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		add_segment('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
		add_segment(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
		add_segment(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
		add_segment(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1'b1);
		add_segment(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 1'b1);
		add_segment(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 1'b0);
		add_segment('0, '0, 16'sh0100, 16'sh0200, 16'sh0200, 16'sh0400,
			16'sh0300, 16'sh0600, 1'b1);
		add_segment(-1, 1, 1, -1, -1, 1, 1, -1, 1'b1);
		add_segment(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA,
			16'shAAAA, 16'sh5555, 1'b0);
		add_segment(16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
			16'sh5555, 16'shAAAA, 1'b1);
		wait_idle();

		// A single step: one point per segment, two for a final one.
		set_steps(32'd1);
		add_segment(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1'b1);
		add_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0);
		wait_idle();

		// Zero in the register behaves exactly like one step.
		set_steps(32'd0);
		add_segment(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 1'b1);
		add_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0);
		wait_idle();

		// Two steps: t = 0, one half, and one for the final segment.
		set_steps(32'd2);
		add_segment(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768, 1'b1);
		add_segment(-3, 5, 7, -9, 11, -13, -15, 17, 1'b0);
		wait_idle();

		// Random paths under a run of settings. An all-ones write gives 63,
		// and a write with bit six set must keep only the low six bits.
		set_steps(32'hFFFF_FFFF);
		queue_paths(22);
		wait_idle();

		set_steps(32'($urandom_range(3, 62)));
		queue_paths(22);
		wait_idle();

		set_steps(32'h0000_0045);
		queue_paths(22);
		wait_idle();

		set_steps(32'd1);
		queue_paths(22);
		wait_idle();

		set_steps(32'($urandom_range(2, 62)) | ($urandom & 32'hFFFF_FFC0));
		queue_paths(22);
		wait_idle();

		// Give any stray point from the pipeline a chance to show itself.
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
